// ----- hw/rtl/brc_pkg.sv -----
// Shared types, constants and helpers of the barometer reading compensation block.
`default_nettype none
package brc_pkg;
	localparam int RAW_W  = 24;
	localparam int CAL_W  = 16;
	localparam int IDX_W  = 3;
	localparam int DT_W   = 26;
	localparam int VAL_W  = 22;
	localparam int MA_W   = 26;
	localparam int MB_W   = 18;
	localparam int PROD_W = MA_W + MB_W;
	localparam int SENS_W = 34;
	localparam int WIDE_W = 58;

	localparam int SPLIT_W = 17;

	localparam int TEMP_SHIFT  = 23;
	localparam int OFF_SHIFT   = 7;
	localparam int SENS_SHIFT  = 8;
	localparam int P_SHIFT     = 21;
	localparam int FINAL_SHIFT = 15;

	localparam int TEMP_BASE = 2000;
	localparam int TEMP_MAX  = 8500;
	localparam int TEMP_MIN  = -4000;

	localparam logic KIND_TEMP  = 1'b0;
	localparam logic KIND_PRESS = 1'b1;

	localparam logic [IDX_W-1:0] REG_PRESSURE_SENSITIVITY  = 3'd0;
	localparam logic [IDX_W-1:0] REG_PRESSURE_OFFSET       = 3'd1;
	localparam logic [IDX_W-1:0] REG_SENSITIVITY_TEMP_COEF = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFFSET_TEMP_COEF      = 3'd3;
	localparam logic [IDX_W-1:0] REG_REFERENCE_TEMPERATURE = 3'd4;
	localparam logic [IDX_W-1:0] REG_TEMPERATURE_SLOPE     = 3'd5;

	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef struct packed {
		logic [CAL_W-1:0] pressure_sensitivity;
		logic [CAL_W-1:0] pressure_offset;
		logic [CAL_W-1:0] sensitivity_temp_coef;
		logic [CAL_W-1:0] offset_temp_coef;
		logic [CAL_W-1:0] reference_temperature;
		logic [CAL_W-1:0] temperature_slope;
	} cal_t;

	// arithmetic shift right that rounds toward zero
	function automatic wide_t trunc_shr(input wide_t x, input int unsigned sh);
		wide_t bias;
		bias = x[WIDE_W-1] ? ((wide_t'(1) <<< sh) - wide_t'(1)) : wide_t'(0);
		return (x + bias) >>> sh;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/brc_if.sv -----
// Valid/ready channel interfaces for measurement and result items.
`default_nettype none
interface brc_in_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [brc_pkg::RAW_W-1:0] raw_count;

	modport source(output valid, output kind, output raw_count, input ready);
	modport sink(input valid, input kind, input raw_count, output ready);
endinterface

interface brc_out_if;
	logic                              valid;
	logic                              ready;
	logic                              result_kind;
	logic signed [brc_pkg::VAL_W-1:0] value;

	modport source(output valid, output result_kind, output value, input ready);
	modport sink(input valid, input result_kind, input value, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/brc_cfg.sv -----
// Calibration coefficient register file.
`default_nettype none
module brc_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [brc_pkg::IDX_W-1:0] wr_index,
	input  wire logic [brc_pkg::CAL_W-1:0] wr_data,
	output brc_pkg::cal_t                   cal
);
	brc_pkg::cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				brc_pkg::REG_PRESSURE_SENSITIVITY:  cal_q.pressure_sensitivity  <= wr_data;
				brc_pkg::REG_PRESSURE_OFFSET:       cal_q.pressure_offset       <= wr_data;
				brc_pkg::REG_SENSITIVITY_TEMP_COEF: cal_q.sensitivity_temp_coef <= wr_data;
				brc_pkg::REG_OFFSET_TEMP_COEF:      cal_q.offset_temp_coef      <= wr_data;
				brc_pkg::REG_REFERENCE_TEMPERATURE: cal_q.reference_temperature <= wr_data;
				brc_pkg::REG_TEMPERATURE_SLOPE:     cal_q.temperature_slope     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cal = cal_q;
endmodule
`default_nettype wire

// ----- hw/rtl/brc_mul.sv -----
// Shared signed multiplier with registered product.
`default_nettype none
module brc_mul (
	input  wire logic                               clk,
	input  wire logic signed [brc_pkg::MA_W-1:0]   a,
	input  wire logic signed [brc_pkg::MB_W-1:0]   b,
	output logic signed      [brc_pkg::PROD_W-1:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= brc_pkg::PROD_W'(a) * brc_pkg::PROD_W'(b);
	end
endmodule
`default_nettype wire

// ----- hw/rtl/barometer_reading_compensation.sv -----
// Top level: first-order barometer compensation with a shared multiplier and sequencer.
//
// Usage:
//   meas   : sink channel, one item = kind (0 temperature, 1 pressure) and a
//            24-bit raw conversion count. Accepted on valid && ready.
//   result : source channel, one item per measurement: result_kind echoes kind,
//            value is temperature in 0.01 degC (clamped -4000..8500) or pressure
//            in 0.01 mbar (low 22 bits, not clamped).
//   wr_en/wr_index/wr_data : coefficient writes, indexes 0..5, others ignored.
// From accept to result valid, a temperature item steps through T_DT, T_MUL, T_ADD
// and T_FIN, a pressure item through P_M0 to P_FIN. The block takes one item at a
// time: ready is high only while the sequencer is idle, so no new item is taken
// until the last one is through. The steps are the passes through the one 26x18
// multiplier plus the wide add steps that follow each pass.
// A temperature item stores dT; pressure items use the latest stored dT.
// Reset clears the coefficients, dT and the result register.
// If the receiver stalls, the finished result holds in the output register; a
// new item may still be accepted, and its result waits until the slot frees.
`default_nettype none
module barometer_reading_compensation (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	brc_in_if.sink                          meas,
	brc_out_if.source                       result,
	input  wire logic                       wr_en,
	input  wire logic [brc_pkg::IDX_W-1:0] wr_index,
	input  wire logic [brc_pkg::CAL_W-1:0] wr_data
);
	typedef enum logic [3:0] {
		IDLE, T_DT, T_MUL, T_ADD, T_FIN,
		P_M0, P_M1, P_SENS, P_MLO, P_MHI, P_FULL, P_Q, P_SUB, P_FIN
	} state_t;

	state_t                                state_q;
	brc_pkg::cal_t                         cal;
	logic                                  kind_q;
	logic        [brc_pkg::RAW_W-1:0]     raw_q;
	logic signed [brc_pkg::DT_W-1:0]      dt_q;
	brc_pkg::wide_t                        acc_q;
	brc_pkg::wide_t                        off_q;
	logic signed [brc_pkg::SENS_W-1:0]    sens_q;
	logic signed [brc_pkg::MA_W-1:0]      mul_a;
	logic signed [brc_pkg::MB_W-1:0]      mul_b;
	logic signed [brc_pkg::PROD_W-1:0]    prod_q;
	brc_pkg::wide_t                        prod_w;
	brc_pkg::wide_t                        p_fin;
	brc_pkg::wide_t                        t_clamp;
	logic                                  res_valid_q;
	logic                                  res_kind_q;
	logic signed [brc_pkg::VAL_W-1:0]     res_value_q;
	logic                                  slot_free;
	logic                                  res_load;
	logic                                  accept;

	brc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cal      (cal)
	);

	brc_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign meas.ready = (state_q == IDLE);
	assign accept     = meas.valid && meas.ready;
	assign slot_free  = !res_valid_q || result.ready;
	assign res_load   = ((state_q == T_FIN) || (state_q == P_FIN)) && slot_free;
	assign prod_w     = brc_pkg::wide_t'(prod_q);
	assign p_fin      = brc_pkg::trunc_shr(acc_q, brc_pkg::FINAL_SHIFT);

	always_comb begin
		priority if (acc_q > brc_pkg::wide_t'(brc_pkg::TEMP_MAX)) begin
			t_clamp = brc_pkg::wide_t'(brc_pkg::TEMP_MAX);
		end else if (acc_q < brc_pkg::wide_t'(brc_pkg::TEMP_MIN)) begin
			t_clamp = brc_pkg::wide_t'(brc_pkg::TEMP_MIN);
		end else begin
			t_clamp = acc_q;
		end
	end

	always_comb begin
		mul_a = dt_q;
		mul_b = '0;
		unique case (state_q)
			T_MUL:   mul_b = $signed({2'b00, cal.temperature_slope});
			P_M0:    mul_b = $signed({2'b00, cal.offset_temp_coef});
			P_M1:    mul_b = $signed({2'b00, cal.sensitivity_temp_coef});
			P_MLO: begin
				mul_a = $signed({2'b00, raw_q});
				mul_b = $signed({1'b0, sens_q[brc_pkg::SPLIT_W-1:0]});
			end
			P_MHI: begin
				mul_a = $signed({2'b00, raw_q});
				mul_b = $signed({sens_q[brc_pkg::SENS_W-1],
					sens_q[brc_pkg::SENS_W-1:brc_pkg::SPLIT_W]});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			dt_q        <= '0;
			acc_q       <= '0;
			off_q       <= '0;
			sens_q      <= '0;
			res_valid_q <= 1'b0;
			res_kind_q  <= 1'b0;
			res_value_q <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= (meas.kind == brc_pkg::KIND_TEMP) ? T_DT : P_M0;
					end
				end
				T_DT: begin
					dt_q    <= $signed({2'b00, raw_q})
						- $signed({2'b00, cal.reference_temperature, 8'h00});
					state_q <= T_MUL;
				end
				T_MUL:  state_q <= T_ADD;
				T_ADD: begin
					acc_q   <= brc_pkg::trunc_shr(prod_w, brc_pkg::TEMP_SHIFT)
						+ brc_pkg::wide_t'(brc_pkg::TEMP_BASE);
					state_q <= T_FIN;
				end
				T_FIN: begin
					if (slot_free) begin
						res_kind_q  <= kind_q;
						res_value_q <= t_clamp[brc_pkg::VAL_W-1:0];
						state_q     <= IDLE;
					end
				end
				P_M0:   state_q <= P_M1;
				P_M1: begin
					off_q   <= brc_pkg::wide_t'({cal.pressure_offset, 16'h0000})
						+ brc_pkg::trunc_shr(prod_w, brc_pkg::OFF_SHIFT);
					state_q <= P_SENS;
				end
				P_SENS: begin
					sens_q  <= brc_pkg::SENS_W'(
						brc_pkg::wide_t'({cal.pressure_sensitivity, 15'h0000})
						+ brc_pkg::trunc_shr(prod_w, brc_pkg::SENS_SHIFT));
					state_q <= P_MLO;
				end
				P_MLO:  state_q <= P_MHI;
				P_MHI: begin
					acc_q   <= prod_w;
					state_q <= P_FULL;
				end
				P_FULL: begin
					acc_q   <= acc_q + (prod_w <<< brc_pkg::SPLIT_W);
					state_q <= P_Q;
				end
				P_Q: begin
					acc_q   <= brc_pkg::trunc_shr(acc_q, brc_pkg::P_SHIFT);
					state_q <= P_SUB;
				end
				P_SUB: begin
					acc_q   <= acc_q - off_q;
					state_q <= P_FIN;
				end
				P_FIN: begin
					if (slot_free) begin
						res_kind_q  <= kind_q;
						res_value_q <= p_fin[brc_pkg::VAL_W-1:0];
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= meas.kind;
			raw_q  <= meas.raw_count;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.result_kind = res_kind_q;
	assign result.value       = res_value_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !meas.ready)
		else $error("ready stayed high after an item was accepted");

	a_temp_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.result_kind == brc_pkg::KIND_TEMP) |->
		(result.value <= brc_pkg::VAL_W'(brc_pkg::TEMP_MAX)
		&& result.value >= brc_pkg::VAL_W'(brc_pkg::TEMP_MIN)))
		else $error("temperature result outside clamp range");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == T_FIN || $past(state_q) == P_FIN))
		else $error("result raised outside a finishing step");

	a_dt_only_on_temp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != T_DT) |=> $stable(dt_q))
		else $error("stored dT changed outside a temperature item");
`endif
endmodule
`default_nettype wire
